// ===== rtl/core/lc_pkg.sv =====
`timescale 1ns / 1ps
// lc_pkg: shared constants and types for the linear convolution block.
// No dependencies; used by the interfaces, the cell and the top level.
package lc_pkg;

  localparam int MAX_LEN  = 32;
  localparam int SAMPLE_W = 16;

  localparam int PROD_W   = 2 * SAMPLE_W;
  // worst case: MAX_LEN products of magnitude 2^(2*SAMPLE_W-2); the signed
  // product width already carries the sign, so log2(MAX_LEN) more bits suffice
  localparam int VALUE_W  = PROD_W + $clog2(MAX_LEN);
  localparam int CNT_W    = $clog2(MAX_LEN + 1);
  localparam int INDEX_W  = $clog2(2 * MAX_LEN - 1);

  localparam logic CMD_LOAD_A = 1'b0;
  localparam logic CMD_LOAD_B = 1'b1;

  // per-cell control, driven by the top level
  typedef struct packed {
    logic load_a;   // write sample into this cell's first-sequence slot
    logic load_b;   // write sample into this cell's second-sequence slot
    logic advance;  // one step of the convolution chain
    logic first;    // first step of a run: ignore neighbor's partial sum
    logic active;   // cell index is below the first-sequence length
  } lc_cell_ctl_t;

endpackage

// ===== rtl/core/lc_if.sv =====
`timescale 1ns / 1ps
// lc_in_if / lc_out_if: valid/ready channels for sample loads and results.
// Depends on lc_pkg.
interface lc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic signed [lc_pkg::SAMPLE_W-1:0]   sample;
  logic                                 last;

  modport source (output valid, command, sample, last, input ready);
  modport sink   (input valid, command, sample, last, output ready);
endinterface

interface lc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lc_pkg::VALUE_W-1:0]    value;
  logic        [lc_pkg::INDEX_W-1:0]    index;
  logic                                 final_res;

  modport source (output valid, value, index, final_res, input ready);
  modport sink   (input valid, value, index, final_res, output ready);
endinterface

// ===== rtl/core/lc_cell.sv =====
`timescale 1ns / 1ps
// lc_cell: one tap of the transposed convolution chain.
// Holds one sample of each sequence and one partial sum. Depends on lc_pkg.
module lc_cell (
  input  logic                                clk,
  input  lc_pkg::lc_cell_ctl_t                ctl,
  input  logic signed [lc_pkg::SAMPLE_W-1:0]  sample,
  input  logic signed [lc_pkg::SAMPLE_W-1:0]  x,
  input  logic signed [lc_pkg::SAMPLE_W-1:0]  b_in,
  input  logic signed [lc_pkg::VALUE_W-1:0]   s_in,
  output logic signed [lc_pkg::SAMPLE_W-1:0]  b_out,
  output logic signed [lc_pkg::VALUE_W-1:0]   s_out
);

  logic signed [lc_pkg::SAMPLE_W-1:0] a_r;
  logic signed [lc_pkg::SAMPLE_W-1:0] b_r;
  logic signed [lc_pkg::VALUE_W-1:0]  s_r;
  logic signed [lc_pkg::PROD_W-1:0]   mult;
  logic signed [lc_pkg::PROD_W-1:0]   prod;
  logic signed [lc_pkg::VALUE_W-1:0]  s_nxt;

  assign mult  = a_r * x;  // both operands signed: sign-extended multiply
  assign prod  = ctl.active ? mult : '0;
  assign s_nxt = lc_pkg::VALUE_W'(prod) + (ctl.first ? '0 : s_in);

  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      a_r <= sample;
    end
    if (ctl.load_b) begin
      b_r <= sample;
    end else if (ctl.advance) begin
      b_r <= b_in;  // second sequence walks toward cell 0
    end
    if (ctl.advance) begin
      s_r <= s_nxt;
    end
  end

  assign b_out = b_r;
  assign s_out = s_r;

endmodule

// ===== rtl/core/linear_convolution.sv =====
`timescale 1ns / 1ps
// linear_convolution: full linear convolution of two signed sample sequences.
// Depends on lc_pkg, lc_in_if, lc_out_if and lc_cell.
//
// Usage
//   in_ch  : one transaction per sample. command 0 appends to the first
//            sequence, command 1 to the second. Each holds up to MAX_LEN
//            samples; extra samples are dropped. command 1 with last = 1
//            appends its sample and starts a run.
//   out_ch : a run delivers na+nb-1 transactions, value = exact sum of
//            products, index = 0,1,..., final_res set on the last one. When
//            the first sequence is empty nothing is delivered. Both sequence
//            lengths return to zero when a run starts.
//   Timing : the chain of MAX_LEN cells (one multiply-add each) retires one
//            result per step. The starting transaction moves the sequencer
//            to its run state; the first step then registers the first
//            result in cell 0's partial-sum register, the output register.
//            in_ch.ready is low for the length of a run.
//   Stall  : cell 0's partial-sum register is the output register; the chain
//            steps only when it is empty or being taken, so a stalled
//            receiver freezes the whole run with nothing lost.
//   Reset  : rst_n (synchronous, active low) clears both lengths and the
//            control state; sample storage is not cleared.
module linear_convolution (
  input  logic        clk,
  input  logic        rst_n,
  lc_in_if.sink       in_ch,
  lc_out_if.source    out_ch
);

  localparam int N = lc_pkg::MAX_LEN;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                         state_r;
  logic [lc_pkg::CNT_W-1:0]       first_count_r;
  logic [lc_pkg::CNT_W-1:0]       second_count_r;
  logic [lc_pkg::CNT_W-1:0]       na_r;
  logic [lc_pkg::CNT_W-1:0]       nb_r;
  logic [lc_pkg::CNT_W-1:0]       nb_run;
  logic [lc_pkg::INDEX_W-1:0]     t_r;
  logic [lc_pkg::INDEX_W-1:0]     last_t_r;
  logic [lc_pkg::INDEX_W-1:0]     out_index_r;
  logic                           out_final_r;
  logic                           out_valid_r;

  logic                           in_acc;
  logic                           load_a;
  logic                           load_b;
  logic                           start;
  logic                           advance;
  logic                           b_room;
  logic signed [lc_pkg::SAMPLE_W-1:0] x;

  logic signed [lc_pkg::SAMPLE_W-1:0] b_chain [N+1];
  logic signed [lc_pkg::VALUE_W-1:0]  s_chain [N+1];

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign load_a      = in_acc && (in_ch.command == lc_pkg::CMD_LOAD_A);
  assign load_b      = in_acc && (in_ch.command == lc_pkg::CMD_LOAD_B);
  assign start       = load_b && in_ch.last;

  // second-sequence length including the sample of the starting transaction
  assign b_room = (second_count_r < lc_pkg::CNT_W'(N));
  assign nb_run = second_count_r + lc_pkg::CNT_W'(b_room);

  // chain steps when the output slot (cell 0's sum) is free or being taken
  assign advance = (state_r == ST_RUN) && (!out_valid_r || out_ch.ready);

  // broadcast input: second sequence sample, zero once it is used up
  assign x = (t_r < lc_pkg::INDEX_W'(nb_r)) ? b_chain[0] : '0;

  assign b_chain[N] = '0;
  assign s_chain[N] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    lc_pkg::lc_cell_ctl_t ctl;

    assign ctl.load_a  = load_a && (first_count_r == lc_pkg::CNT_W'(i));
    assign ctl.load_b  = load_b && (second_count_r == lc_pkg::CNT_W'(i));
    assign ctl.advance = advance;
    assign ctl.first   = (t_r == '0);
    assign ctl.active  = (na_r > lc_pkg::CNT_W'(i));

    lc_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .sample (in_ch.sample),
      .x      (x),
      .b_in   (b_chain[i+1]),
      .s_in   (s_chain[i+1]),
      .b_out  (b_chain[i]),
      .s_out  (s_chain[i])
    );
  end

  // sequence lengths
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_count_r  <= '0;
      second_count_r <= '0;
    end else if (start) begin
      first_count_r  <= '0;
      second_count_r <= '0;
    end else begin
      if (load_a && (first_count_r < lc_pkg::CNT_W'(N))) begin
        first_count_r <= first_count_r + 1'b1;
      end
      if (load_b && b_room) begin
        second_count_r <= second_count_r + 1'b1;
      end
    end
  end

  // run sequencer and output flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      na_r        <= '0;
      nb_r        <= '0;
      t_r         <= '0;
      last_t_r    <= '0;
      out_index_r <= '0;
      out_final_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (out_valid_r && out_ch.ready) begin
            out_valid_r <= 1'b0;
          end
          if (start && (first_count_r != '0)) begin
            state_r  <= ST_RUN;
            na_r     <= first_count_r;
            nb_r     <= nb_run;
            t_r      <= '0;
            last_t_r <= lc_pkg::INDEX_W'(first_count_r) + lc_pkg::INDEX_W'(nb_run)
                        - lc_pkg::INDEX_W'(2);
          end
        end
        ST_RUN: begin
          if (advance) begin
            out_valid_r <= 1'b1;
            out_index_r <= t_r;
            out_final_r <= (t_r == last_t_r);
            t_r         <= t_r + 1'b1;
            if (t_r == last_t_r) begin
              state_r <= ST_IDLE;
            end
          end else if (out_ch.ready) begin
            out_valid_r <= 1'b0;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value     = s_chain[0];
  assign out_ch.index     = out_index_r;
  assign out_ch.final_res = out_final_r;

endmodule

// ===== rtl/core/lc_checker.sv =====
`timescale 1ns / 1ps
// lc_checker: port-level checks for linear_convolution, bound to the top.
// Depends on lc_pkg.
module lc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [lc_pkg::VALUE_W-1:0]  out_value,
  input logic [lc_pkg::INDEX_W-1:0]         out_index,
  input logic                               out_final
);

  logic [lc_pkg::INDEX_W-1:0] exp_idx_r;

  // expected position of the next result within its run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else if (out_valid && out_ready) begin
      exp_idx_r <= out_final ? '0 : out_index + 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value)
      && $stable(out_index) && $stable(out_final))
    else $error("result changed while stalled");

  a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_index == exp_idx_r)
    else $error("result index out of sequence");

  a_no_load_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final |-> !in_ready)
    else $error("input taken while a run is in progress");

endmodule

bind linear_convolution lc_checker u_lc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.value),
  .out_index (out_ch.index),
  .out_final (out_ch.final_res)
);

// ===== sim/lc_conv_checker.sv =====
`timescale 1ns / 1ps
// lc_conv_checker: predicts and checks the convolution results of linear_convolution.
// Depends on lc_pkg, lc_in_if and lc_out_if. It only observes both channels.
module lc_conv_checker
  import lc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lc_in_if     in_ch,
  lc_out_if    out_ch,
  output int   mismatch_count,
  output int   pending_terms
);

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic        [INDEX_W-1:0] index;
    logic                      final_res;
  } conv_term_t;

  logic signed [SAMPLE_W-1:0] seq_a [MAX_LEN];
  logic signed [SAMPLE_W-1:0] seq_b [MAX_LEN];
  int                         len_a;
  int                         len_b;
  conv_term_t                 conv_terms_q[$];

  // full convolution of the loaded samples, one term per output position
  task automatic predict_convolution();
    longint     acc;
    int         n_terms;
    int         lo;
    int         hi;
    conv_term_t term;
    n_terms = len_a + len_b - 1;
    for (int k = 0; k < n_terms; k++) begin
      acc = 0;
      lo  = (k >= len_b) ? k - len_b + 1 : 0;
      hi  = (k < len_a) ? k : len_a - 1;
      for (int i = lo; i <= hi; i++)
        acc += longint'(seq_a[i]) * longint'(seq_b[k - i]);
      term.value     = acc[VALUE_W-1:0];
      term.index     = k[INDEX_W-1:0];
      term.final_res = (k == n_terms - 1);
      conv_terms_q.push_back(term);
    end
  endtask

  initial mismatch_count = 0;

  always @(posedge clk) begin
    conv_term_t want;
    if (!rst_n) begin
      len_a = 0;
      len_b = 0;
      conv_terms_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.command == CMD_LOAD_A) begin
          // last is ignored on the first sequence; full sequences drop samples
          if (len_a < MAX_LEN) begin
            seq_a[len_a] = in_ch.sample;
            len_a++;
          end
        end else begin
          if (len_b < MAX_LEN) begin
            seq_b[len_b] = in_ch.sample;
            len_b++;
          end
          if (in_ch.last) begin
            if (len_a != 0 && len_b != 0)
              predict_convolution();
            len_a = 0;
            len_b = 0;
          end
        end
      end

      if (out_ch.valid && out_ch.ready) begin
        if (conv_terms_q.size() == 0) begin
          $error("unexpected result: index %0d value %0d", out_ch.index, out_ch.value);
          mismatch_count++;
        end else begin
          want = conv_terms_q.pop_front();
          if (out_ch.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_ch.value);
            mismatch_count++;
          end
          if (out_ch.index !== want.index) begin
            $error("index: expected %0d, got %0d", want.index, out_ch.index);
            mismatch_count++;
          end
          if (out_ch.final_res !== want.final_res) begin
            $error("final_res: expected %0b, got %0b", want.final_res, out_ch.final_res);
            mismatch_count++;
          end
        end
      end
    end
    pending_terms = conv_terms_q.size();
  end

endmodule

// ===== sim/tb_linear_convolution.sv =====
`timescale 1ns / 1ps
// tb_linear_convolution: stimulus, flow control and verdict for linear_convolution.
// Depends on lc_pkg, lc_in_if, lc_out_if, lc_conv_checker and the block itself.
module tb_linear_convolution;
  import lc_pkg::*;

  localparam int RANDOM_ITEMS   = 280;
  localparam int HOLDOFF_CYCLES = 400;   // long receiver stall, fills the block
  localparam int IDLE_LIMIT     = 4000;  // cycles without any transaction
  localparam int TAIL_CYCLES    = 50;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   pending_terms;
  int   idle_cycles = 0;
  int   holdoffs_requested = 0;
  int   burst_left = 0;
  int   items_sent = 0;

  lc_in_if  in_ch ();
  lc_out_if out_ch ();

  linear_convolution dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lc_conv_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .pending_terms  (pending_terms)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog: a run that stops moving on both channels is a failure.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_linear_convolution: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result receiver. Stall pattern steps through four phases: always ready,
  // coin flip, one stall in five, mostly stalled. A hold-off request from the
  // stimulus forces a long stall while the sender keeps offering samples.
  initial begin : receiver
    int cyc;
    int served;
    cyc    = 0;
    served = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (served != holdoffs_requested) begin
        served = holdoffs_requested;
        out_ch.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        cyc += HOLDOFF_CYCLES;
      end
      case ((cyc / 97) % 4)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(1));
        2:       out_ch.ready <= (cyc % 5) != 0;
        default: out_ch.ready <= ($urandom_range(3) == 0);
      endcase
    end
  end

  // One sample transaction. Called at a falling edge, returns at the falling
  // edge after acceptance with valid still high, so back-to-back items never
  // drop valid. Bursts of random length are separated by random gaps; about a
  // quarter of the gaps are zero, which gives long unbroken stretches.
  task automatic send_sample(logic cmd, logic signed [SAMPLE_W-1:0] s, logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.sample  <= s;
    in_ch.last    <= lst;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Sender goes quiet until every predicted result has been delivered.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_terms != 0);
  endtask

  // mode 0: full range, 1: corner values, otherwise most negative sample
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(int mode);
    logic signed [SAMPLE_W-1:0] s;
    if (mode == 0) begin
      s = SAMPLE_W'($urandom);
    end else if (mode == 1) begin
      case ($urandom_range(4))
        0:       s = SAMPLE_MIN;
        1:       s = SAMPLE_MAX;
        2:       s = '0;
        3:       s = SAMPLE_W'(1);
        default: s = SAMPLE_W'(-1);
      endcase
    end else begin
      s = SAMPLE_MIN;
    end
    return s;
  endfunction

  // Sequence length: mostly short, some medium, some at or past capacity so
  // that extra samples are dropped (the closing sample included).
  function automatic int pick_len(int min_len);
    int r;
    r = $urandom_range(99);
    if (r < 5)
      return min_len;
    else if (r < 75)
      return $urandom_range(6, 1);
    else if (r < 90)
      return $urandom_range(31, 7);
    else
      return $urandom_range(MAX_LEN + 4, MAX_LEN);
  endfunction

  // One well-formed run: first and second sequence samples interleaved at
  // random, a few first-sequence samples carrying a stray last flag, then
  // the closing second-sequence sample with last set.
  task automatic send_run();
    int na;
    int nb;
    int mode;
    int left_a;
    int left_b;
    na   = pick_len(0);
    nb   = pick_len(1);
    mode = $urandom_range(9);
    mode = (mode < 6) ? 0 : (mode < 9) ? 1 : 2;
    left_a = na;
    left_b = nb - 1;
    while (left_a + left_b > 0) begin
      if (left_a > 0 && (left_b == 0 || $urandom_range(3) != 0)) begin
        send_sample(CMD_LOAD_A, pick_sample(mode), $urandom_range(7) == 0);
        left_a--;
      end else begin
        send_sample(CMD_LOAD_B, pick_sample(mode), 1'b0);
        left_b--;
      end
    end
    send_sample(CMD_LOAD_B, pick_sample(mode), 1'b1);
  endtask

  initial begin : stimulus
    int rand_start;
    int runs;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_LOAD_A;
    in_ch.sample  = '0;
    in_ch.last    = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed ---
    // most negative squared: largest single product
    send_sample(CMD_LOAD_A, SAMPLE_MIN, 1'b0);
    send_sample(CMD_LOAD_B, SAMPLE_MIN, 1'b1);
    // both extremes in both sequences
    send_sample(CMD_LOAD_A, SAMPLE_MAX, 1'b0);
    send_sample(CMD_LOAD_A, SAMPLE_MIN, 1'b0);
    send_sample(CMD_LOAD_B, SAMPLE_MAX, 1'b0);
    send_sample(CMD_LOAD_B, SAMPLE_MIN, 1'b1);
    // last on the first sequence is ignored, sample still loaded
    send_sample(CMD_LOAD_A, 16'sd5, 1'b1);
    send_sample(CMD_LOAD_A, -16'sd3, 1'b0);
    send_sample(CMD_LOAD_B, 16'sd7, 1'b1);
    // empty first sequence: no results, both lengths cleared
    send_sample(CMD_LOAD_B, 16'sd100, 1'b0);
    send_sample(CMD_LOAD_B, -16'sd200, 1'b1);
    drain_results();
    // the cleared second sequence must not leak into this run
    send_sample(CMD_LOAD_A, 16'sd1, 1'b0);
    send_sample(CMD_LOAD_B, -16'sd1, 1'b1);
    // zero samples
    send_sample(CMD_LOAD_A, '0, 1'b0);
    send_sample(CMD_LOAD_B, '0, 1'b1);
    // single-sample second sequence
    send_sample(CMD_LOAD_A, 16'sd1, 1'b0);
    send_sample(CMD_LOAD_A, 16'sd2, 1'b0);
    send_sample(CMD_LOAD_A, 16'sd3, 1'b0);
    send_sample(CMD_LOAD_B, -16'sd1, 1'b1);
    // single-sample first sequence
    send_sample(CMD_LOAD_A, SAMPLE_MIN, 1'b0);
    send_sample(CMD_LOAD_B, SAMPLE_MAX, 1'b0);
    send_sample(CMD_LOAD_B, 16'sd1, 1'b0);
    send_sample(CMD_LOAD_B, -16'sd1, 1'b1);
    drain_results();

    // --- random ---
    // long receiver stall right away: the run freezes and input backs up
    holdoffs_requested++;
    rand_start = items_sent;
    runs       = 0;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      send_run();
      runs++;
      if (runs % 8 == 0)
        drain_results();
      if (runs == 20)
        holdoffs_requested++;
    end

    // --- wrap-up ---
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("tb_linear_convolution: done, clean");
    else
      $display("tb_linear_convolution: done, errors");
    $finish;
  end

endmodule
